@@ rtl/dtp_pkg.sv @@
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared widths, codes and word types of the drift-time to hit-position unit.
// ----------------------------------------------------------------------------
package dtp_pkg;

  localparam int MAX_KNOTS_DEFAULT = 32;

  localparam int TIME_W   = 16;
  localparam int DIST_W   = 16;
  localparam int POS_W    = 24;
  localparam int HITX_W   = 25;
  localparam int SIGN_W   = 2;
  localparam int SEG_W    = 5;
  localparam int IDX_IN_W = 5;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 56;

  localparam int SEGS_RESET = 1;

  // item kind on the input tuser
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_CONVERT = 1'b1;

  // divider: quotient bits and bits resolved per pipeline stage
  localparam int QUO_W    = 16;
  localparam int DIV_BITS = 4;

  typedef struct packed {
    logic [IDX_IN_W-1:0] idx;
    logic [TIME_W-1:0]   t;
    logic [DIST_W-1:0]   d;
  } knot_t;

  typedef struct packed {
    logic [TIME_W-1:0]        dtime;
    logic signed [POS_W-1:0]  wire_x;
    logic signed [POS_W-1:0]  wire_z;
    logic signed [SIGN_W-1:0] side_sign;
  } hit_t;

  typedef struct packed {
    logic             load;
    logic             found;
    logic [SEG_W-1:0] seg;
    knot_t            knot;
    hit_t             hit;
  } srch_t;

  typedef struct packed {
    hit_t              hit;
    logic [SEG_W-1:0]  seg;
    logic              found;
    logic              dneg;
    logic [DIST_W-1:0] x1;
  } tag_t;

  typedef struct packed {
    hit_t              hit;
    logic [SEG_W-1:0]  seg;
    logic              found;
    logic [DIST_W-1:0] dlen;
  } res_t;

endpackage

@@ rtl/dtp_search.sv @@
// ----------------------------------------------------------------------------
// dtp_search
// Knot time bank, parallel segment compare and first-match priority encode.
// ----------------------------------------------------------------------------
module dtp_search #(
  parameter int MAX_KNOTS = dtp_pkg::MAX_KNOTS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  dtp_pkg::knot_t           in_knot,
  input  dtp_pkg::hit_t            in_hit,
  input  logic [dtp_pkg::SEG_W-1:0] segs,
  output logic                     out_valid,
  input  logic                     out_ready,
  output dtp_pkg::srch_t           out_word
);

  localparam int SEG_MAX = (1 << dtp_pkg::SEG_W) - 1;
  localparam int NSEG    = (MAX_KNOTS - 1 < SEG_MAX) ? MAX_KNOTS - 1 : SEG_MAX;

  logic [dtp_pkg::TIME_W-1:0] bank [NSEG+1];
  logic [NSEG:0]              ge;
  logic [NSEG-1:0]            hitv_next;

  logic                v1;
  logic                mode1;
  dtp_pkg::knot_t      knot1;
  dtp_pkg::hit_t       hit1;
  logic [NSEG-1:0]     hitv1;
  logic                en1;
  logic                en2;
  logic                v2;
  dtp_pkg::srch_t      word2;
  logic [dtp_pkg::SEG_W-1:0] seg_next;
  logic                found_next;

  assign en2      = ~v2 | out_ready;
  assign en1      = ~v1 | en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    for (int j = 0; j <= NSEG; j++) begin
      if (in_valid && en1 && in_mode == dtp_pkg::MODE_LOAD &&
          in_knot.idx == dtp_pkg::IDX_IN_W'(j)) begin
        bank[j] <= in_knot.t;
      end
    end
  end

  always_comb begin
    for (int j = 0; j <= NSEG; j++) begin
      ge[j] = in_hit.dtime >= bank[j];
    end
    for (int j = 0; j < NSEG; j++) begin
      hitv_next[j] = ge[j] & ~ge[j+1] & (dtp_pkg::SEG_W'(j) < segs);
    end
  end

  always_comb begin
    seg_next   = '0;
    found_next = 1'b0;
    for (int j = NSEG - 1; j >= 0; j--) begin
      if (hitv1[j]) begin
        seg_next   = dtp_pkg::SEG_W'(j);
        found_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
    if (en1) begin
      mode1 <= in_mode;
      knot1 <= in_knot;
      hit1  <= in_hit;
      hitv1 <= hitv_next;
    end
    if (en2) begin
      word2.load  <= (mode1 == dtp_pkg::MODE_LOAD);
      word2.found <= found_next;
      word2.seg   <= seg_next;
      word2.knot  <= knot1;
      word2.hit   <= hit1;
    end
  end

  assign out_valid = v2;
  assign out_word  = word2;

endmodule

@@ rtl/dtp_div.sv @@
// ----------------------------------------------------------------------------
// dtp_div
// Pipelined restoring divider, 32 by 16 bits, quotient known to fit 16 bits.
// ----------------------------------------------------------------------------
module dtp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2*dtp_pkg::QUO_W-1:0] dividend,
  input  logic [dtp_pkg::QUO_W-1:0] divisor,
  input  dtp_pkg::tag_t             in_tag,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dtp_pkg::QUO_W-1:0] quotient,
  output dtp_pkg::tag_t             out_tag
);

  localparam int QW  = dtp_pkg::QUO_W;
  localparam int NST = QW / dtp_pkg::DIV_BITS;

  logic          v    [NST];
  logic          en   [NST];
  logic [QW-1:0] rem  [NST];
  logic [QW-1:0] low  [NST];
  logic [QW-1:0] quo  [NST];
  logic [QW-1:0] den  [NST];
  dtp_pkg::tag_t tag  [NST];

  logic          v_in   [NST];
  logic [QW-1:0] rem_in [NST];
  logic [QW-1:0] low_in [NST];
  logic [QW-1:0] quo_in [NST];
  logic [QW-1:0] den_in [NST];
  dtp_pkg::tag_t tag_in [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [QW:0]   t_c;
    logic [QW-1:0] r_c;
    logic [QW-1:0] l_c;
    logic [QW-1:0] q_c;

    if (k == 0) begin : g_first
      assign v_in[k]   = in_valid;
      assign rem_in[k] = dividend[2*QW-1:QW];
      assign low_in[k] = dividend[QW-1:0];
      assign quo_in[k] = '0;
      assign den_in[k] = divisor;
      assign tag_in[k] = in_tag;
    end else begin : g_next
      assign v_in[k]   = v[k-1];
      assign rem_in[k] = rem[k-1];
      assign low_in[k] = low[k-1];
      assign quo_in[k] = quo[k-1];
      assign den_in[k] = den[k-1];
      assign tag_in[k] = tag[k-1];
    end

    if (k == NST - 1) begin : g_last_en
      assign en[k] = ~v[k] | out_ready;
    end else begin : g_mid_en
      assign en[k] = ~v[k] | en[k+1];
    end

    always_comb begin
      r_c = rem_in[k];
      l_c = low_in[k];
      q_c = quo_in[k];
      t_c = '0;
      for (int b = 0; b < dtp_pkg::DIV_BITS; b++) begin
        t_c = {r_c, l_c[QW-1]};
        l_c = {l_c[QW-2:0], 1'b0};
        if (t_c >= {1'b0, den_in[k]}) begin
          r_c = QW'(t_c - {1'b0, den_in[k]});
          q_c = {q_c[QW-2:0], 1'b1};
        end else begin
          r_c = t_c[QW-1:0];
          q_c = {q_c[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v_in[k];
      end
      if (en[k]) begin
        rem[k] <= r_c;
        low[k] <= l_c;
        quo[k] <= q_c;
        den[k] <= den_in[k];
        tag[k] <= tag_in[k];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];
  assign quotient  = quo[NST-1];
  assign out_tag   = tag[NST-1];

endmodule

@@ rtl/dtp_interp.sv @@
// ----------------------------------------------------------------------------
// dtp_interp
// Knot memories, segment differences, product, divide and distance sum.
// ----------------------------------------------------------------------------
module dtp_interp #(
  parameter int MAX_KNOTS = dtp_pkg::MAX_KNOTS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  dtp_pkg::srch_t in_word,
  output logic           out_valid,
  input  logic           out_ready,
  output dtp_pkg::res_t  out_word
);

  localparam int IDX_W = $clog2(MAX_KNOTS);
  localparam int TW    = dtp_pkg::TIME_W;
  localparam int DW    = dtp_pkg::DIST_W;

  logic [TW-1:0] time_mem [MAX_KNOTS];
  logic [DW-1:0] dist_mem [MAX_KNOTS];

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_lo;
  logic [IDX_W-1:0] rd_hi;

  logic en3, en4, en5, en6;
  logic v3, v4, v5, v6;
  logic div_ready;

  // stage 3: knot reads
  logic [TW-1:0]             t1_3, t2_3;
  logic [DW-1:0]             x1_3, x2_3;
  dtp_pkg::hit_t             hit3;
  logic [dtp_pkg::SEG_W-1:0] seg3;
  logic                      found3;

  // stage 4: differences
  logic [DW:0]   dx;
  logic [DW-1:0] dmag4, num4, den4;
  dtp_pkg::tag_t tag4;

  // stage 5: product
  logic [2*DW-1:0] prod5;
  logic [DW-1:0]   den5;
  dtp_pkg::tag_t   tag5;

  // divider out and stage 6
  logic                        dv;
  logic [dtp_pkg::QUO_W-1:0]   quo;
  dtp_pkg::tag_t               dtag;
  logic [DW+1:0]               qx;
  logic [DW+1:0]               sum;
  dtp_pkg::res_t               res6;

  assign en6      = ~v6 | out_ready;
  assign en5      = ~v5 | div_ready;
  assign en4      = ~v4 | en5;
  assign en3      = ~v3 | en4;
  assign in_ready = en3;

  assign wr_en   = in_valid & in_word.load & en3 & (int'(in_word.knot.idx) < MAX_KNOTS);
  assign wr_addr = IDX_W'(in_word.knot.idx);
  assign rd_lo   = IDX_W'(in_word.seg);
  assign rd_hi   = IDX_W'({1'b0, in_word.seg} + 1'b1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr] <= in_word.knot.t;
      dist_mem[wr_addr] <= in_word.knot.d;
    end
    if (en3) begin
      t1_3   <= time_mem[rd_lo];
      t2_3   <= time_mem[rd_hi];
      x1_3   <= dist_mem[rd_lo];
      x2_3   <= dist_mem[rd_hi];
      hit3   <= in_word.hit;
      seg3   <= in_word.seg;
      found3 <= in_word.found;
    end
  end

  assign dx = {1'b0, x2_3} - {1'b0, x1_3};

  always_ff @(posedge clk) begin
    if (en4) begin
      dmag4      <= dx[DW] ? DW'(~dx + 1'b1) : dx[DW-1:0];
      num4       <= hit3.dtime - t1_3;
      den4       <= t2_3 - t1_3;
      tag4.hit   <= hit3;
      tag4.seg   <= seg3;
      tag4.found <= found3;
      tag4.dneg  <= dx[DW];
      tag4.x1    <= x1_3;
    end
    if (en5) begin
      prod5 <= dmag4 * num4;
      den5  <= den4;
      tag5  <= tag4;
    end
  end

  dtp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_ready  (div_ready),
    .dividend  (prod5),
    .divisor   (den5),
    .in_tag    (tag5),
    .out_valid (dv),
    .out_ready (en6),
    .quotient  (quo),
    .out_tag   (dtag)
  );

  // truncation toward zero: divide magnitudes, then restore the sign
  assign qx  = {2'b00, quo};
  assign sum = {2'b00, dtag.x1} + (dtag.dneg ? (~qx + 1'b1) : qx);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en3) v3 <= in_valid & ~in_word.load;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= dv;
    end
    if (en6) begin
      res6.hit   <= dtag.hit;
      res6.seg   <= dtag.seg;
      res6.found <= dtag.found;
      res6.dlen  <= dtag.found ? sum[DW-1:0] : '0;
    end
  end

  assign out_valid = v6;
  assign out_word  = res6;

endmodule

@@ rtl/drift_time_to_hit_position_unit.sv @@
// ----------------------------------------------------------------------------
// drift_time_to_hit_position_unit
// Drift-chamber hit to position converter, piecewise-linear calibration.
//
// Takes one word per clock while the output is not held off and returns one
// result per convert word; load words give no result. Behind the segment
// search, knot read, difference and product stages sits the four-stage
// divider (four quotient bits a stage). A load word is seen by every convert
// word accepted after it. Stalls on the output side fill empty stages first,
// so input stays open while bubbles remain. Knot times must ascend over the
// segments in use; knots that were never loaded give undefined positions when
// a search reaches them.
// ----------------------------------------------------------------------------
module drift_time_to_hit_position_unit #(
  parameter int MAX_KNOTS = dtp_pkg::MAX_KNOTS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // knot_index, knot_time, knot_distance, drift_time, wire_x, wire_z, side_sign
  input  logic [dtp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // mode
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // hit_x, hit_z, segment
  output logic [dtp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // found
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dtp_pkg::SEG_W-1:0]         cfg_data
);

  localparam int HW  = dtp_pkg::HITX_W;
  localparam int PW  = dtp_pkg::POS_W;
  localparam int DW  = dtp_pkg::DIST_W;
  localparam int SGW = dtp_pkg::SEG_W;

  logic [SGW-1:0] segs;

  dtp_pkg::knot_t in_knot;
  dtp_pkg::hit_t  in_hit;

  logic           srch_valid, srch_ready;
  dtp_pkg::srch_t srch_word;
  logic           res_valid, res_ready;
  dtp_pkg::res_t  res_word;

  logic signed [HW-1:0] offset;
  logic signed [HW-1:0] hit_x_next;

  logic                 out_valid;
  logic signed [HW-1:0] out_hit_x;
  logic signed [PW-1:0] out_hit_z;
  logic [SGW-1:0]       out_seg;
  logic                 out_found;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      segs <= SGW'(dtp_pkg::SEGS_RESET);
    end else if (cfg_valid) begin
      segs <= cfg_data;
    end
  end

  assign in_knot.idx          = s_axis_tdata[4:0];
  assign in_knot.t            = s_axis_tdata[20:5];
  assign in_knot.d            = s_axis_tdata[36:21];
  assign in_hit.dtime         = s_axis_tdata[52:37];
  assign in_hit.wire_x        = s_axis_tdata[76:53];
  assign in_hit.wire_z        = s_axis_tdata[100:77];
  assign in_hit.side_sign     = s_axis_tdata[102:101];

  dtp_search #(.MAX_KNOTS(MAX_KNOTS)) u_search (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .in_knot   (in_knot),
    .in_hit    (in_hit),
    .segs      (segs),
    .out_valid (srch_valid),
    .out_ready (srch_ready),
    .out_word  (srch_word)
  );

  dtp_interp #(.MAX_KNOTS(MAX_KNOTS)) u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (srch_valid),
    .in_ready  (srch_ready),
    .in_word   (srch_word),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_word  (res_word)
  );

  // side sign times distance; pattern 10 counts as minus two
  always_comb begin
    unique case (res_word.hit.side_sign)
      2'b01:   offset = $signed({{(HW-DW){1'b0}}, res_word.dlen});
      2'b11:   offset = -$signed({{(HW-DW){1'b0}}, res_word.dlen});
      2'b10:   offset = -$signed({{(HW-DW-1){1'b0}}, res_word.dlen, 1'b0});
      default: offset = '0;
    endcase
  end

  assign hit_x_next = $signed({res_word.hit.wire_x[PW-1], res_word.hit.wire_x}) + offset;

  assign res_ready = ~out_valid | m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready) begin
      out_hit_x <= hit_x_next;
      out_hit_z <= res_word.hit.wire_z;
      out_seg   <= res_word.seg;
      out_found <= res_word.found;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_seg, out_hit_z, out_hit_x};
  assign m_axis_tuser  = out_found;

  // input is only held off while a result waits at the output
  a_ready_hold: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with output empty");

  // a miss reports segment zero
  a_miss_seg: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> out_seg == '0)
    else $error("segment set on a miss");

  // nothing leaves the pipeline straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule
